// ----- rtl/dptp_pkg.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: shared package
// Types, codes and helpers shared by the slot memories, the picker and the
// top level.
// ----------------------------------------------------------------------------
package dptp_pkg;

	// Table geometry.
	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = $clog2(TASK_SLOTS);

	// Request kinds.
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_SELECT = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// Reset value of the immediate window register.
	localparam logic [15:0] WINDOW_RST = 16'd5000;

	// Scheduling part of a slot: rewritten by both write and done requests.
	typedef struct packed {
		logic [31:0] due;
		logic        never;
	} sched_t;

	// Work part of a slot: rewritten by write requests only.
	typedef struct packed {
		logic [7:0]  prio;
		logic [31:0] run;
	} work_t;

	localparam int SCHED_W = $bits(sched_t);
	localparam int WORK_W  = $bits(work_t);

	localparam sched_t SCHED_RST = '{due: 32'd0, never: 1'b1};
	localparam work_t  WORK_RST  = '{prio: 8'd0, run: 32'd0};

	// Start of a select request towards the picker.
	typedef struct packed {
		logic        start;
		logic [31:0] now;
	} sel_req_t;

	// True when the wrapping time a lies strictly after b.
	function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return !d[31] && (d != 32'd0);
	endfunction

endpackage

// ----- rtl/dptp_ram.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: slot memory
// Single write port, single registered read port. Per-entry valid bits make
// an entry that was never written read back as the reset value.
// ----------------------------------------------------------------------------
module dptp_ram #(
	parameter int               WIDTH   = 8,
	parameter int               DEPTH   = 16,
	parameter logic [WIDTH-1:0] RST_VAL = '0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	// Storage array.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Entry valid bits, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Registered read; unwritten entries give the reset value.
	always_ff @(posedge clk) begin
		rdata_q <= valid_q[raddr] ? mem[raddr] : RST_VAL;
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/dptp_picker.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: selection sequencer
// Runs two read sweeps over the slot memories for each select request and
// holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module dptp_picker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dptp_pkg::sel_req_t            req,
	input  dptp_pkg::sched_t              sched,
	input  dptp_pkg::work_t               work,
	input  logic [15:0]                   window,
	output logic [dptp_pkg::SLOT_W-1:0]   rd_addr,
	output logic                          busy,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic                          found,
	output logic [3:0]                    chosen_slot,
	output logic                          run_now,
	output logic [15:0]                   wait_time
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_P0   = 3'd1;
	localparam logic [2:0] ST_GAP0 = 3'd2;
	localparam logic [2:0] ST_PK   = 3'd3;
	localparam logic [2:0] ST_GAP1 = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [dptp_pkg::SLOT_W-1:0] LAST = dptp_pkg::SLOT_W'(dptp_pkg::TASK_SLOTS - 1);

	logic [2:0]                  st_q;
	logic [dptp_pkg::SLOT_W-1:0] cnt_q;
	logic [31:0]                 now_q;

	// Read data tag, registered from the address like the read data itself.
	logic                        vld_s1;
	logic                        pass_s1;
	logic [dptp_pkg::SLOT_W-1:0] idx_s1;

	// Best deadline-class task.
	logic                        p0_found_q;
	logic [dptp_pkg::SLOT_W-1:0] p0_idx_q;
	logic [31:0]                 p0_due_q;
	logic [31:0]                 slack_q;

	// Best overdue priority task.
	logic                        pk_found_q;
	logic [dptp_pkg::SLOT_W-1:0] pk_idx_q;
	logic [31:0]                 pk_due_q;
	logic [7:0]                  pk_prio_q;

	// Output register.
	logic        out_valid_q;
	logic        found_q;
	logic [3:0]  slot_q;
	logic        run_now_q;
	logic [15:0] wait_q;

	logic take_p0;
	logic take_pk;
	logic load_out;
	logic any_found;
	logic [dptp_pkg::SLOT_W-1:0] pick_idx;
	logic [31:0] pick_due;
	logic [31:0] w;
	logic        w_run_now;
	logic [15:0] w_wait;

	assign rd_addr = cnt_q;
	assign busy    = (st_q != ST_IDLE);

	// Sweep one: earliest-due deadline-class task.
	always_comb begin
		take_p0 = vld_s1 && !pass_s1 && (sched.never == 1'b0) && (work.prio == 8'd0) &&
			(!p0_found_q || dptp_pkg::later_than(p0_due_q, sched.due));
	end

	// Sweep two: overdue task that still finishes before the deadline task.
	always_comb begin
		take_pk = vld_s1 && pass_s1 && (sched.never == 1'b0) && (work.prio != 8'd0) &&
			!dptp_pkg::later_than(sched.due, now_q) &&
			(!p0_found_q || dptp_pkg::later_than(slack_q, work.run)) &&
			(!pk_found_q || (pk_prio_q > work.prio) ||
			 ((pk_prio_q == work.prio) && dptp_pkg::later_than(pk_due_q, sched.due)));
	end

	// Result formatting from the chosen slot.
	always_comb begin
		any_found = pk_found_q || p0_found_q;
		pick_idx  = pk_found_q ? pk_idx_q : p0_idx_q;
		pick_due  = pk_found_q ? pk_due_q : p0_due_q;
		w         = pick_due - now_q;
		w_run_now = $signed({w[31], w}) < $signed({17'd0, window});
		if (w[31]) begin
			w_wait = 16'd0;
		end else if (|w[30:16]) begin
			w_wait = 16'hFFFF;
		end else begin
			w_wait = w[15:0];
		end
	end

	assign load_out = (st_q == ST_FIN) && (!out_valid_q || !out_stall);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			pass_s1 <= 1'b0;
		end else begin
			vld_s1  <= (st_q == ST_P0) || (st_q == ST_PK);
			pass_s1 <= (st_q == ST_PK);
			unique case (st_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req.start) begin
						st_q <= ST_P0;
					end
				end
				ST_P0: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						st_q  <= ST_GAP0;
					end
				end
				ST_GAP0: begin
					st_q <= ST_PK;
				end
				ST_PK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						st_q  <= ST_GAP1;
					end
				end
				ST_GAP1: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sweep tag for the read data.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// Candidate flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_found_q <= 1'b0;
			pk_found_q <= 1'b0;
		end else if (req.start && (st_q == ST_IDLE)) begin
			p0_found_q <= 1'b0;
			pk_found_q <= 1'b0;
		end else begin
			if (take_p0) begin
				p0_found_q <= 1'b1;
			end
			if (take_pk) begin
				pk_found_q <= 1'b1;
			end
		end
	end

	// Candidate payload and the deadline slack used by sweep two.
	always_ff @(posedge clk) begin
		if (req.start && (st_q == ST_IDLE)) begin
			now_q <= req.now;
		end
		if (take_p0) begin
			p0_idx_q <= idx_s1;
			p0_due_q <= sched.due;
		end
		if (take_pk) begin
			pk_idx_q  <= idx_s1;
			pk_due_q  <= sched.due;
			pk_prio_q <= work.prio;
		end
		if (st_q == ST_PK) begin
			slack_q <= p0_due_q - now_q;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q   <= any_found;
			slot_q    <= any_found ? 4'(pick_idx) : 4'd0;
			run_now_q <= any_found && w_run_now;
			wait_q    <= any_found ? w_wait : 16'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign chosen_slot = slot_q;
	assign run_now     = run_now_q;
	assign wait_time   = wait_q;

endmodule

// ----- rtl/deadline_priority_task_picker_unit.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: top level
// Slot table in two synchronous memories, write and done requests applied
// directly, select requests served by a two-sweep picker.
// ----------------------------------------------------------------------------
// Usage:
// Input requests arrive on in_valid / in_stall with their fields as separate
// ports. A write request sets a whole slot, a done request sets the due time
// and never flag of a slot (clamped up to now_time when the slot is active).
// Neither gives a result. A select request makes one result on
// out_valid / out_stall.
// A select request runs two sweeps of TASK_SLOTS memory reads, one read per
// cycle on the single read port, plus turnaround and output formatting.
// in_stall stays high until the select result is loaded, so the next request
// waits for that. If the result is still held by the receiver when the next
// select finishes, the picker waits until the output register frees.
// immediate_window is written over cfg_valid / cfg_ready; the user must write
// it only while the block is idle, which the block itself does not enforce.
// cfg_ready is always high. Reset marks every slot as never due, clears all
// pending work and sets the window to 5000.
// ----------------------------------------------------------------------------
module deadline_priority_task_picker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot_index,
	input  logic [7:0]  task_priority_in,
	input  logic [31:0] due_time_in,
	input  logic        never_in,
	input  logic [31:0] run_length_in,
	input  logic [31:0] now_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] immediate_window,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [3:0]  chosen_slot,
	output logic        run_now,
	output logic [15:0] wait_time
);

	logic                        accept;
	logic                        slot_ok;
	logic                        we_sched;
	logic                        we_work;
	logic [dptp_pkg::SLOT_W-1:0] waddr;
	logic [dptp_pkg::SLOT_W-1:0] raddr;
	logic                        busy;
	logic [15:0]                 window_q;
	dptp_pkg::sched_t            sched_wr;
	dptp_pkg::sched_t            sched_rd;
	dptp_pkg::work_t             work_wr;
	dptp_pkg::work_t             work_rd;
	dptp_pkg::sel_req_t          sel_req;

	assign in_stall  = busy;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign slot_ok   = {28'd0, slot_index} < 32'(dptp_pkg::TASK_SLOTS);
	assign waddr     = dptp_pkg::SLOT_W'(slot_index);

	// Window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= dptp_pkg::WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= immediate_window;
		end
	end

	// Write path: done requests clamp an active past due time up to now.
	always_comb begin
		we_sched       = accept && slot_ok &&
			((kind == dptp_pkg::KIND_WRITE) || (kind == dptp_pkg::KIND_DONE));
		we_work        = accept && slot_ok && (kind == dptp_pkg::KIND_WRITE);
		sched_wr.never = never_in;
		sched_wr.due   = due_time_in;
		if ((kind == dptp_pkg::KIND_DONE) && !never_in &&
			dptp_pkg::later_than(now_time, due_time_in)) begin
			sched_wr.due = now_time;
		end
		work_wr.prio = task_priority_in;
		work_wr.run  = run_length_in;
	end

	assign sel_req.start = accept && (kind == dptp_pkg::KIND_SELECT);
	assign sel_req.now   = now_time;

	// Due time and never flag per slot.
	dptp_ram #(
		.WIDTH   (dptp_pkg::SCHED_W),
		.DEPTH   (dptp_pkg::TASK_SLOTS),
		.RST_VAL (dptp_pkg::SCHED_RST)
	) u_sched_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_sched),
		.waddr  (waddr),
		.wdata  (sched_wr),
		.raddr  (raddr),
		.rdata  (sched_rd)
	);

	// Priority and run length per slot.
	dptp_ram #(
		.WIDTH   (dptp_pkg::WORK_W),
		.DEPTH   (dptp_pkg::TASK_SLOTS),
		.RST_VAL (dptp_pkg::WORK_RST)
	) u_work_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we_work),
		.waddr  (waddr),
		.wdata  (work_wr),
		.raddr  (raddr),
		.rdata  (work_rd)
	);

	// Selection sequencer and output register.
	dptp_picker u_picker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (sel_req),
		.sched       (sched_rd),
		.work        (work_rd),
		.window      (window_q),
		.rd_addr     (raddr),
		.busy        (busy),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found       (found),
		.chosen_slot (chosen_slot),
		.run_now     (run_now),
		.wait_time   (wait_time)
	);

endmodule

// ----- rtl/dptp_checker.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: port checker
// Watches the top-level ports for result and request ordering slips.
// ----------------------------------------------------------------------------
module dptp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [3:0]  chosen_slot,
	input logic        run_now,
	input logic [15:0] wait_time
);

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// An empty pick carries no slot, no urgency and no wait.
	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (chosen_slot == 4'd0) && !run_now && (wait_time == 16'd0))
		else $error("empty pick with non-zero fields");

	// A select request keeps the input side busy in the next cycle.
	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == dptp_pkg::KIND_SELECT) |=> in_stall)
		else $error("select request did not occupy the picker");

	// Write and done requests never raise a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind != dptp_pkg::KIND_SELECT) |=> !$rose(out_valid))
		else $error("result raised by a non-select request");

endmodule

bind deadline_priority_task_picker_unit dptp_checker u_dptp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.chosen_slot (chosen_slot),
	.run_now     (run_now),
	.wait_time   (wait_time)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Deadline priority task picker: testbench
// Sends write, select and done requests into the picker. Both sides of the
// handshake idle at random. A model of the slot table predicts each select
// result not typed into the directed table, and each result is compared with
// its expectation field by field. A short table of directed requests comes
// first. Random phases follow under several window settings, with one stretch
// of no idling, one long hold on the result side and one pause of the sender.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Request kind that the block ignores.
	localparam logic [1:0] KIND_NOP = 2'd3;

	localparam int IDLE_PCT       = 10;
	localparam int PICK_LATENCY   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 5;
	localparam int PHASE_REQUESTS = 285;
	localparam int MAX_PRINTED    = 50;

	typedef struct packed {
		logic        found;
		logic [3:0]  slot;
		logic        run_now;
		logic [15:0] wait_us;
	} pick_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  prio;
		logic [31:0] due;
		logic        never;
		logic [31:0] run;
		logic [31:0] now_us;
	} task_req_t;

	// One directed request, with its result typed in where it is obvious.
	typedef struct packed {
		task_req_t req;
		logic      typed;
		pick_t     want;
	} dir_row_t;

	localparam pick_t NO_PICK = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [3:0]  slot_index;
	logic [7:0]  task_priority_in;
	logic [31:0] due_time_in;
	logic        never_in;
	logic [31:0] run_length_in;
	logic [31:0] now_time;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] immediate_window;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [3:0]  chosen_slot;
	logic        run_now;
	logic [15:0] wait_time;

	// Model of the slot table and the window register.
	logic [31:0] tbl_due [dptp_pkg::TASK_SLOTS];
	logic        tbl_never [dptp_pkg::TASK_SLOTS];
	logic [7:0]  tbl_prio [dptp_pkg::TASK_SLOTS];
	logic [31:0] tbl_run [dptp_pkg::TASK_SLOTS];
	logic [15:0] win_reg;

	pick_t       pick_queue [$];
	dir_row_t    dir_rows [$];
	int          mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	logic        row_typed;
	pick_t       row_want;
	logic [31:0] clock_base;

	deadline_priority_task_picker_unit i_dut (.*);

	always #10 clk = ~clk;

	// Signed difference of two wrapping microsecond times.
	function automatic int wdiff(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return $signed(d);
	endfunction

	// Works out which slot a select at now_v picks from the modelled table.
	function automatic pick_t predict_pick(input logic [31:0] now_v);
		int    early;
		int    urgent;
		int    chosen;
		int    gap;
		pick_t res;
		early = -1;
		urgent = -1;
		// Earliest due deadline-class task.
		for (int i = 0; i < dptp_pkg::TASK_SLOTS; i++) begin
			if (tbl_prio[i] == 8'd0 && !tbl_never[i]) begin
				if (early < 0 || wdiff(tbl_due[early], tbl_due[i]) > 0)
					early = i;
			end
		end
		// Overdue tasks that would finish before that deadline.
		for (int i = 0; i < dptp_pkg::TASK_SLOTS; i++) begin
			if (!tbl_never[i] && tbl_prio[i] != 8'd0 && wdiff(tbl_due[i], now_v) <= 0) begin
				if (early < 0 || wdiff(tbl_due[early], now_v + tbl_run[i]) > 0) begin
					if (urgent < 0 || tbl_prio[urgent] > tbl_prio[i] ||
						(tbl_prio[urgent] == tbl_prio[i] &&
						wdiff(tbl_due[urgent], tbl_due[i]) > 0))
						urgent = i;
				end
			end
		end
		res = NO_PICK;
		chosen = (urgent >= 0) ? urgent : early;
		if (chosen >= 0) begin
			gap = wdiff(tbl_due[chosen], now_v);
			res.found = 1'b1;
			res.slot = 4'(chosen);
			res.run_now = (gap < int'(win_reg));
			res.wait_us = (gap <= 0) ? 16'd0 : (gap > 65535) ? 16'hFFFF : 16'(gap);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Results are checked first, then the model takes any accepted request.
	always @(posedge clk) begin
		pick_t got;
		pick_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {found, chosen_slot, run_now, wait_time};
				if (pick_queue.size() == 0) begin
					report_mismatch($sformatf("result for slot %0d with nothing expected",
						chosen_slot));
				end else begin
					want = pick_queue.pop_front();
					if (got.found !== want.found)
						report_mismatch($sformatf("found %0d, expected %0d",
							got.found, want.found));
					if (got.slot !== want.slot)
						report_mismatch($sformatf("chosen_slot %0d, expected %0d",
							got.slot, want.slot));
					if (got.run_now !== want.run_now)
						report_mismatch($sformatf("run_now %0d, expected %0d",
							got.run_now, want.run_now));
					if (got.wait_us !== want.wait_us)
						report_mismatch($sformatf("wait_time %0d, expected %0d",
							got.wait_us, want.wait_us));
				end
			end
			if (cfg_valid && cfg_ready)
				win_reg = immediate_window;
			if (in_valid && !in_stall) begin
				case (kind)
					dptp_pkg::KIND_WRITE: begin
						tbl_prio[slot_index] = task_priority_in;
						tbl_due[slot_index] = due_time_in;
						tbl_never[slot_index] = never_in;
						tbl_run[slot_index] = run_length_in;
					end
					dptp_pkg::KIND_DONE: begin
						// An active slot is never left due before the current time.
						if (!never_in && wdiff(due_time_in, now_time) < 0)
							tbl_due[slot_index] = now_time;
						else
							tbl_due[slot_index] = due_time_in;
						tbl_never[slot_index] = never_in;
					end
					dptp_pkg::KIND_SELECT: begin
						pick_queue.push_back(row_typed ? row_want : predict_pick(now_time));
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result side: random stalls, or a long hold when one is asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Ends the run when nothing at all is accepted for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic add_row(input logic [1:0] k, input logic [3:0] s, input logic [7:0] p,
		input logic [31:0] d, input logic nv, input logic [31:0] rl, input logic [31:0] nw,
		input logic typed, input pick_t want);
		dir_rows.push_back({k, s, p, d, nv, rl, nw, typed, want});
	endtask

	// Offers one request after a random gap and holds it until it is taken.
	task automatic send_request(input task_req_t r, input logic typed, input pick_t want);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		slot_index <= r.slot;
		task_priority_in <= r.prio;
		due_time_in <= r.due;
		never_in <= r.never;
		run_length_in <= r.run;
		now_time <= r.now_us;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// The window is only written once the picker has gone quiet.
	task automatic write_window(input logic [15:0] v);
		in_valid <= 1'b0;
		while (pick_queue.size() != 0) @(posedge clk);
		// Writes and dones give no result, so let a select still in flight drain.
		repeat (PICK_LATENCY) @(posedge clk);
		cfg_valid <= 1'b1;
		immediate_window <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Requests clustered around a moving time base, with some noise.
	function automatic task_req_t random_request();
		task_req_t   r;
		int unsigned roll;
		clock_base = clock_base + 32'($urandom_range(0, 3000));
		roll = $urandom_range(0, 99);
		if (roll < 38)
			r.kind = dptp_pkg::KIND_WRITE;
		else if (roll < 72)
			r.kind = dptp_pkg::KIND_SELECT;
		else if (roll < 95)
			r.kind = dptp_pkg::KIND_DONE;
		else
			r.kind = KIND_NOP;
		r.slot = 4'($urandom_range(0, dptp_pkg::TASK_SLOTS - 1));
		roll = $urandom_range(0, 99);
		if (roll < 45)
			r.prio = 8'd0;
		else if (roll < 85)
			r.prio = 8'($urandom_range(1, 3));
		else
			r.prio = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 10)
			r.due = $urandom();
		else
			r.due = clock_base + 32'($urandom_range(0, 40000)) - 32'd20000;
		r.never = ($urandom_range(0, 99) < 20);
		roll = $urandom_range(0, 99);
		if (roll < 60)
			r.run = $urandom_range(0, 30000);
		else if (roll < 90)
			r.run = $urandom_range(0, 200000);
		else
			r.run = $urandom();
		if ($urandom_range(0, 99) < 5)
			r.now_us = $urandom();
		else
			r.now_us = clock_base + 32'($urandom_range(0, 2000));
		// Now and then every field is drawn over its whole range.
		if ($urandom_range(0, 99) < 5) begin
			r.kind = 2'($urandom_range(0, 3));
			r.prio = 8'($urandom_range(0, 255));
			r.due = $urandom();
			r.never = 1'($urandom_range(0, 1));
			r.run = $urandom();
			r.now_us = $urandom();
		end
		return r;
	endfunction

	// Main sequence: reset, directed table, then the random phases.
	initial begin
		task_req_t   r;
		int          sent;
		int          step;
		logic [15:0] win_v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = dptp_pkg::KIND_WRITE;
		slot_index = 4'd0;
		task_priority_in = 8'd0;
		due_time_in = 32'd0;
		never_in = 1'b0;
		run_length_in = 32'd0;
		now_time = 32'd0;
		cfg_valid = 1'b0;
		immediate_window = dptp_pkg::WINDOW_RST;
		row_typed = 1'b0;
		row_want = NO_PICK;
		for (int i = 0; i < dptp_pkg::TASK_SLOTS; i++) begin
			tbl_due[i] = 32'd0;
			tbl_never[i] = 1'b1;
			tbl_prio[i] = 8'd0;
			tbl_run[i] = 32'd0;
		end
		win_reg = dptp_pkg::WINDOW_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every slot is inactive, so nothing can be chosen.
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			NO_PICK);
		add_row(KIND_NOP, 4'd15, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd15, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1, NO_PICK);
		// A single deadline task inside the window.
		add_row(dptp_pkg::KIND_WRITE, 4'd0, 8'd0, 32'd1000, 1'b0, 32'd0, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			{1'b1, 4'd0, 1'b1, 16'd1000});
		// Equal deadlines go to the lower slot.
		add_row(dptp_pkg::KIND_WRITE, 4'd15, 8'd0, 32'd1000, 1'b0, 32'd0, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			{1'b1, 4'd0, 1'b1, 16'd1000});
		add_row(dptp_pkg::KIND_WRITE, 4'd0, 8'd0, 32'd100000, 1'b0, 32'd0, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			{1'b1, 4'd15, 1'b1, 16'd1000});
		// A long wait saturates and is outside the window.
		add_row(dptp_pkg::KIND_WRITE, 4'd15, 8'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1,
			{1'b1, 4'd0, 1'b0, 16'hFFFF});
		// An overdue short task replaces the deadline task.
		add_row(dptp_pkg::KIND_WRITE, 4'd5, 8'hFF, 32'd50, 1'b0, 32'd10, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd100, 1'b1,
			{1'b1, 4'd5, 1'b1, 16'd0});
		// Lower priority number wins, and a run length that wraps still fits.
		add_row(dptp_pkg::KIND_WRITE, 4'd7, 8'd1, 32'd60, 1'b0, 32'hFFFF_FFFF, 32'd0,
			1'b0, NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd100, 1'b0,
			NO_PICK);
		// A run that would overrun the deadline is passed over.
		add_row(dptp_pkg::KIND_WRITE, 4'd8, 8'd1, 32'd40, 1'b0, 32'd200000, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd100, 1'b0,
			NO_PICK);
		// Done requests: clamped when active, written as given when never.
		add_row(dptp_pkg::KIND_DONE, 4'd0, 8'd0, 32'd5, 1'b0, 32'd0, 32'd200, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'd200, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_DONE, 4'd7, 8'd0, 32'd0, 1'b1, 32'd0, 32'd300, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_DONE, 4'd3, 8'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 1'b0,
			NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'h8000_0000,
			1'b0, NO_PICK);
		add_row(dptp_pkg::KIND_WRITE, 4'd9, 8'd128, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000,
			32'd0, 1'b0, NO_PICK);
		add_row(dptp_pkg::KIND_SELECT, 4'd0, 8'd0, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF,
			1'b0, NO_PICK);
		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// Random phases, each under its own window setting.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: win_v = 16'd0;
				1: win_v = 16'hFFFF;
				2: win_v = 16'($urandom_range(2, 65534));
				3: win_v = 16'd1;
				default: win_v = dptp_pkg::WINDOW_RST;
			endcase
			write_window(win_v);
			quiet = (p == 1);
			clock_base = (p == PHASES - 1) ? 32'hFFFF_0000 : $urandom();
			if (p == 2)
				hold_req = 1'b1;
			sent = 0;
			step = 0;
			while (sent < PHASE_REQUESTS) begin
				// Midway through one phase the sender waits for every result.
				if (p == 3 && step == PHASE_REQUESTS / 2) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pick_queue.size() != 0);
				end
				r = random_request();
				sent++;
				step++;
				send_request(r, 1'b0, NO_PICK);
			end
		end

		quiet = 1'b0;
		in_valid <= 1'b0;
		do @(posedge clk); while (pick_queue.size() != 0);
		repeat (PICK_LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dptp_pkg.sv
rtl/dptp_ram.sv
rtl/dptp_picker.sv
rtl/deadline_priority_task_picker_unit.sv
rtl/dptp_checker.sv
sim/tb.sv
